FILE: rtl/ptt_pkg.sv
package ptt_pkg;

    localparam int ID_W     = 5;
    localparam int PERIOD_W = 32;
    localparam int NOW_W    = 48;
    localparam int REQ_W    = 2;
    localparam int STS_W    = 3;

    localparam int DEF_NUM_TIMERS = 32;
    localparam int DEF_TIME_BITS  = 48;

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [STS_W-1:0] t_status;

    localparam t_req REQ_START = 2'd0;
    localparam t_req REQ_STOP  = 2'd1;
    localparam t_req REQ_REARM = 2'd2;
    localparam t_req REQ_TICK  = 2'd3;

    localparam t_status STS_OK         = 3'd0;
    localparam t_status STS_BAD_PERIOD = 3'd1;
    localparam t_status STS_NO_TIMER   = 3'd2;
    localparam t_status STS_FULL       = 3'd3;
    localparam t_status STS_FIRED      = 3'd4;
    localparam t_status STS_IDLE       = 3'd5;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic push_ok;
        logic stall;
        logic idx_last;
    } t_sts;

endpackage

FILE: rtl/ptt_controller.sv
module ptt_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ptt_pkg::t_req   i_req_type,
    output logic            o_in_ready,
    input  ptt_pkg::t_sts   i_sts,
    output ptt_pkg::t_cmd   o_cmd
);
    import ptt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = accept;
        o_cmd.exec  = (r_state == S_EXEC) && i_sts.push_ok;
        o_cmd.scan  = (r_state == S_SCAN);
        o_cmd.step  = (r_state == S_SCAN) && !i_sts.stall;
        o_cmd.flush = (r_state == S_FLUSH) && i_sts.push_ok;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req_type == REQ_TICK) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.push_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (o_cmd.step && i_sts.idx_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.push_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/ptt_datapath.sv
module ptt_datapath #(
    parameter int NUM_TIMERS = ptt_pkg::DEF_NUM_TIMERS,
    parameter int TIME_BITS  = ptt_pkg::DEF_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptt_pkg::t_cmd                 i_cmd,
    output ptt_pkg::t_sts                 o_sts,
    input  ptt_pkg::t_req                 i_req_type,
    input  logic [ptt_pkg::PERIOD_W-1:0]  i_period_ms,
    input  logic [ptt_pkg::ID_W-1:0]      i_slot_id,
    input  logic [ptt_pkg::NOW_W-1:0]     i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ptt_pkg::t_status              o_status,
    output logic [ptt_pkg::ID_W-1:0]      o_slot_id_res,
    output logic                          o_last
);
    import ptt_pkg::*;

    localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IDX_W  = (SLOT_W > ID_W) ? SLOT_W : ID_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);
    localparam logic [IDX_W:0]    NUM_EXT   = (IDX_W+1)'(NUM_TIMERS);

    logic [PERIOD_W-1:0]  r_period_mem   [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_deadline_mem [NUM_TIMERS];

    t_req                 r_req;
    logic [PERIOD_W-1:0]  r_period;
    logic [ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0] r_last_tick;
    logic [NUM_TIMERS-1:0] r_active;
    logic [SLOT_W-1:0]    r_idx;
    logic [PERIOD_W-1:0]  r_rd_period;
    logic [TIME_BITS-1:0] r_rd_deadline;
    logic                 r_pend_valid;
    logic [SLOT_W-1:0]    r_pend_id;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [ID_W-1:0]      r_out_id;
    logic                 r_out_last;

    logic                  push_ok;
    logic [NUM_TIMERS-1:0] free;
    logic [NUM_TIMERS-1:0] iso;
    logic                  has_free;
    logic [SLOT_W-1:0]     free_slot;
    logic [IDX_W-1:0]      id_ext;
    logic [SLOT_W-1:0]     id_slot;
    logic                  id_ok;
    logic [PERIOD_W-1:0]   inc;
    logic [TIME_BITS:0]    sum;
    logic [TIME_BITS-1:0]  sat;
    logic                  fire;
    logic [SLOT_W-1:0]     rd_addr;

    t_status              ex_status;
    logic [ID_W-1:0]      ex_id;
    logic                 ex_set;
    logic                 ex_clr;
    logic                 ex_wr;
    logic [SLOT_W-1:0]    ex_addr;

    logic                 per_we;
    logic                 dl_we;
    logic [SLOT_W-1:0]    wr_addr;

    logic                 push;
    t_status              push_status;
    logic [ID_W-1:0]      push_id;
    logic                 push_last;

    assign push_ok = !r_out_valid || i_out_ready;

    assign free     = ~r_active;
    assign iso      = free & (~free + 1'b1);
    assign has_free = |free;

    always_comb begin
        free_slot = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (iso[i]) begin
                free_slot = free_slot | SLOT_W'(i);
            end
        end
    end

    assign id_ext  = IDX_W'(r_id);
    assign id_slot = id_ext[SLOT_W-1:0];
    assign id_ok   = ({1'b0, id_ext} < NUM_EXT) && r_active[id_slot];

    // one shared saturating adder: last tick time plus a period
    assign inc = i_cmd.scan ? r_rd_period : r_period;
    assign sum = {1'b0, r_last_tick} + (TIME_BITS+1)'(inc);
    assign sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    assign fire = r_active[r_idx] && (r_rd_deadline <= r_last_tick);

    always_comb begin
        o_sts          = '0;
        o_sts.push_ok  = push_ok;
        o_sts.stall    = fire && r_pend_valid && !push_ok;
        o_sts.idx_last = (r_idx == LAST_SLOT);
    end

    always_comb begin
        if (i_cmd.load) begin
            rd_addr = '0;
        end else if (i_cmd.step) begin
            rd_addr = r_idx + 1'b1;
        end else begin
            rd_addr = r_idx;
        end
    end

    always_comb begin
        ex_status = STS_IDLE;
        ex_id     = '0;
        ex_set    = 1'b0;
        ex_clr    = 1'b0;
        ex_wr     = 1'b0;
        ex_addr   = id_slot;
        case (r_req)
            REQ_START: begin
                ex_addr = free_slot;
                if (r_period == '0) begin
                    ex_status = STS_BAD_PERIOD;
                end else if (!has_free) begin
                    ex_status = STS_FULL;
                end else begin
                    ex_status = STS_OK;
                    ex_id     = ID_W'(free_slot);
                    ex_set    = 1'b1;
                    ex_wr     = 1'b1;
                end
            end
            REQ_STOP: begin
                ex_id = r_id;
                if (!id_ok) begin
                    ex_status = STS_NO_TIMER;
                end else begin
                    ex_status = STS_OK;
                    ex_clr    = 1'b1;
                end
            end
            REQ_REARM: begin
                ex_id = r_id;
                if (!id_ok) begin
                    ex_status = STS_NO_TIMER;
                end else if (r_period == '0) begin
                    ex_status = STS_BAD_PERIOD;
                end else begin
                    ex_status = STS_OK;
                    ex_wr     = 1'b1;
                end
            end
            default: begin
                ex_status = STS_IDLE;
            end
        endcase
    end

    assign per_we  = i_cmd.exec && ex_wr;
    assign dl_we   = per_we || (i_cmd.step && fire);
    assign wr_addr = i_cmd.exec ? ex_addr : r_idx;

    always_ff @(posedge i_clk) begin
        if (per_we) begin
            r_period_mem[wr_addr] <= r_period;
        end
        if (dl_we) begin
            r_deadline_mem[wr_addr] <= sat;
        end
        r_rd_period   <= r_period_mem[rd_addr];
        r_rd_deadline <= r_deadline_mem[rd_addr];
    end

    always_comb begin
        push        = 1'b0;
        push_status = STS_IDLE;
        push_id     = '0;
        push_last   = 1'b1;
        if (i_cmd.exec) begin
            push        = 1'b1;
            push_status = ex_status;
            push_id     = ex_id;
        end else if (i_cmd.step && fire && r_pend_valid) begin
            push        = 1'b1;
            push_status = STS_FIRED;
            push_id     = ID_W'(r_pend_id);
            push_last   = 1'b0;
        end else if (i_cmd.flush) begin
            push = 1'b1;
            if (r_pend_valid) begin
                push_status = STS_FIRED;
                push_id     = ID_W'(r_pend_id);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_period <= i_period_ms;
            r_id     <= i_slot_id;
        end
        if (i_cmd.step && fire) begin
            r_pend_id <= r_idx;
        end
        if (push) begin
            r_out_status <= push_status;
            r_out_id     <= push_id;
            r_out_last   <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_last_tick  <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.exec && ex_set) begin
                r_active[ex_addr] <= 1'b1;
            end
            if (i_cmd.exec && ex_clr) begin
                r_active[ex_addr] <= 1'b0;
            end
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_pend_valid <= 1'b0;
                if (i_req_type == REQ_TICK) begin
                    r_last_tick <= TIME_BITS'(i_now_ms);
                end
            end else if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
                if (fire) begin
                    r_pend_valid <= 1'b1;
                end
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_id_res = r_out_id;
    assign o_last        = r_out_last;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.exec, i_cmd.step, i_cmd.flush}))
        else $error("conflicting datapath commands");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_pend_valid)
        else $error("pending result survives flush");

    a_mid_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && fire && r_pend_valid) |=> (r_out_valid && !r_out_last
            && r_out_status == STS_FIRED))
        else $error("earlier firing not pushed as non-final result");

    a_final_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.flush) |=> (r_out_valid && r_out_last))
        else $error("final result missing");

endmodule

FILE: rtl/periodic_timer_table.sv
// channel | direction | handshake                     | payload
// input   | in        | i_in_valid / o_in_ready       | req_type, period_ms, slot_id, now_ms
// output  | out       | o_out_valid / i_out_ready     | status, slot_id_res, last
//
// Start, stop and rearm are accepted, then executed into the output register.
// A tick is accepted, then steps through the slots one by one in the period
// and deadline memories (one read and one write port each), then pushes the final result.
// Reset clears the active bits and the tick time at once; no clearing pass.
// A full output register holds the scan on a second firing slot, and holds the
// execute and final cycles, until the waiting result is taken.
module periodic_timer_table #(
    parameter int NUM_TIMERS = ptt_pkg::DEF_NUM_TIMERS,
    parameter int TIME_BITS  = ptt_pkg::DEF_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ptt_pkg::t_req                 i_req_type,
    input  logic [ptt_pkg::PERIOD_W-1:0]  i_period_ms,
    input  logic [ptt_pkg::ID_W-1:0]      i_slot_id,
    input  logic [ptt_pkg::NOW_W-1:0]     i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ptt_pkg::t_status              o_status,
    output logic [ptt_pkg::ID_W-1:0]      o_slot_id_res,
    output logic                          o_last
);
    import ptt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ptt_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptt_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_period_ms   (i_period_ms),
        .i_slot_id     (i_slot_id),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_slot_id_res (o_slot_id_res),
        .o_last        (o_last)
    );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

class timer_table_checker;
    localparam int SLOTS = ptt_pkg::DEF_NUM_TIMERS;

    typedef logic [ptt_pkg::NOW_W-1:0]    t_ms;
    typedef logic [ptt_pkg::PERIOD_W-1:0] t_period;
    typedef logic [ptt_pkg::ID_W-1:0]     t_slot;

    typedef struct {
        ptt_pkg::t_status status;
        t_slot            slot;
        logic             last;
    } t_reply;

    bit      armed [SLOTS];
    t_period period_of [SLOTS];
    t_ms     deadline_of [SLOTS];
    t_ms     tick_time;
    t_reply  awaited_replies [$];
    int      errors;

    function new();
        foreach (armed[i]) armed[i] = 1'b0;
        tick_time = '0;
        errors = 0;
    endfunction

    function t_ms arm_time(t_ms base, t_period period);
        logic [ptt_pkg::NOW_W:0] sum;
        sum = {1'b0, base} + {{(ptt_pkg::NOW_W + 1 - ptt_pkg::PERIOD_W){1'b0}}, period};
        return sum[ptt_pkg::NOW_W] ? '1 : sum[ptt_pkg::NOW_W-1:0];
    endfunction

    function t_reply reply(ptt_pkg::t_status status, int slot);
        t_reply r;
        r.status = status;
        r.slot = t_slot'(slot);
        r.last = 1'b0;
        return r;
    endfunction

    function int count_armed();
        int n;
        n = 0;
        foreach (armed[i]) n += armed[i];
        return n;
    endfunction

    function int random_armed();
        int pool [$];
        foreach (armed[i]) if (armed[i]) pool.insert(pool.size(), i);
        if (pool.size() == 0) return $urandom_range(SLOTS - 1, 0);
        return pool[$urandom_range(pool.size() - 1, 0)];
    endfunction

    function void note_request(ptt_pkg::t_req req, t_period period, t_slot id, t_ms now);
        t_reply batch [$];
        int     free_slot;
        free_slot = -1;
        case (req)
            ptt_pkg::REQ_START: begin
                for (int i = SLOTS - 1; i >= 0; i--) if (!armed[i]) free_slot = i;
                if (period == '0) begin
                    batch.insert(batch.size(), reply(ptt_pkg::STS_BAD_PERIOD, 0));
                end else if (free_slot < 0) begin
                    batch.insert(batch.size(), reply(ptt_pkg::STS_FULL, 0));
                end else begin
                    armed[free_slot] = 1'b1;
                    period_of[free_slot] = period;
                    deadline_of[free_slot] = arm_time(tick_time, period);
                    batch.insert(batch.size(), reply(ptt_pkg::STS_OK, free_slot));
                end
            end
            ptt_pkg::REQ_STOP: begin
                if (!armed[id]) begin
                    batch.insert(batch.size(), reply(ptt_pkg::STS_NO_TIMER, id));
                end else begin
                    armed[id] = 1'b0;
                    batch.insert(batch.size(), reply(ptt_pkg::STS_OK, id));
                end
            end
            ptt_pkg::REQ_REARM: begin
                if (!armed[id]) begin
                    batch.insert(batch.size(), reply(ptt_pkg::STS_NO_TIMER, id));
                end else if (period == '0) begin
                    batch.insert(batch.size(), reply(ptt_pkg::STS_BAD_PERIOD, id));
                end else begin
                    period_of[id] = period;
                    deadline_of[id] = arm_time(tick_time, period);
                    batch.insert(batch.size(), reply(ptt_pkg::STS_OK, id));
                end
            end
            default: begin
                tick_time = now;
                for (int i = 0; i < SLOTS; i++) begin
                    if (armed[i] && deadline_of[i] <= now) begin
                        deadline_of[i] = arm_time(now, period_of[i]);
                        batch.insert(batch.size(), reply(ptt_pkg::STS_FIRED, i));
                    end
                end
                if (batch.size() == 0) begin
                    batch.insert(batch.size(), reply(ptt_pkg::STS_IDLE, 0));
                end
            end
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) awaited_replies.insert(awaited_replies.size(), batch[k]);
    endfunction

    function void compare(string field, int unsigned want, logic [7:0] got);
        if (got !== want[7:0]) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    function void check_result(ptt_pkg::t_status status, t_slot slot, logic last);
        t_reply want;
        if (awaited_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual status %0d id %0d last %0d",
                     $time, status, slot, last);
            return;
        end
        want = awaited_replies.pop_front();
        compare("status", want.status, 8'(status));
        compare("slot_id_res", want.slot, 8'(slot));
        compare("last", want.last, 8'(last));
    endfunction
endclass

module tb;
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    ptt_pkg::t_req                 i_req_type;
    logic [ptt_pkg::PERIOD_W-1:0]  i_period_ms;
    logic [ptt_pkg::ID_W-1:0]      i_slot_id;
    logic [ptt_pkg::NOW_W-1:0]     i_now_ms;
    logic                          o_out_valid;
    logic                          i_out_ready;
    ptt_pkg::t_status              o_status;
    logic [ptt_pkg::ID_W-1:0]      o_slot_id_res;
    logic                          o_last;

    timer_table_checker table_check = new();

    int                        in_idle_max;
    int                        out_idle_max;
    logic [ptt_pkg::NOW_W-1:0] wall_ms;

    periodic_timer_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_period_ms   (i_period_ms),
        .i_slot_id     (i_slot_id),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_slot_id_res (o_slot_id_res),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("periodic_timer_table regression: fail");
        $finish;
    end

    task automatic send(ptt_pkg::t_req req, logic [ptt_pkg::PERIOD_W-1:0] period,
                        logic [ptt_pkg::ID_W-1:0] id, logic [ptt_pkg::NOW_W-1:0] now);
        int gap;
        gap = $urandom_range(in_idle_max, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_period_ms <= period;
        i_slot_id   <= id;
        i_now_ms    <= now;
        do @(posedge i_clk); while (!o_in_ready);
        table_check.note_request(req, period, id, now);
    endtask

    function automatic logic [ptt_pkg::PERIOD_W-1:0] pick_period();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 5) return '0;
        if (sel < 15) return $urandom();
        if (sel < 20) return '1;
        return $urandom_range(40, 1);
    endfunction

    task automatic random_item(int start_pct);
        int                        sel;
        logic [ptt_pkg::NOW_W-1:0] now;
        logic [ptt_pkg::ID_W-1:0]  id;
        sel = $urandom_range(99, 0);
        id = ($urandom_range(9, 0) < 8) ? ptt_pkg::ID_W'(table_check.random_armed())
                                        : ptt_pkg::ID_W'($urandom());
        if (sel < start_pct) begin
            send(ptt_pkg::REQ_START, pick_period(), ptt_pkg::ID_W'($urandom()),
                 ptt_pkg::NOW_W'({$urandom(), $urandom()}));
        end else if (sel < start_pct + 12) begin
            send(ptt_pkg::REQ_STOP, $urandom(), id, ptt_pkg::NOW_W'({$urandom(), $urandom()}));
        end else if (sel < start_pct + 24) begin
            send(ptt_pkg::REQ_REARM, pick_period(), id,
                 ptt_pkg::NOW_W'({$urandom(), $urandom()}));
        end else begin
            sel = $urandom_range(99, 0);
            if (sel < 80) begin
                wall_ms = wall_ms + ptt_pkg::NOW_W'($urandom_range(20, 0));
                now = wall_ms;
            end else if (sel < 88) begin
                now = ptt_pkg::NOW_W'({$urandom(), $urandom()});
            end else if (sel < 93) begin
                now = wall_ms - ptt_pkg::NOW_W'($urandom_range(15, 0));
            end else if (sel < 97) begin
                now = '1;
            end else begin
                now = '0;
            end
            send(ptt_pkg::REQ_TICK, $urandom(), ptt_pkg::ID_W'($urandom()), now);
        end
    endtask

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(out_idle_max, 0);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            table_check.check_result(o_status, o_slot_id_res, o_last);
        end
    end

    initial begin
        int n;
        int start_pct;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_req_type  <= ptt_pkg::REQ_TICK;
        i_period_ms <= '0;
        i_slot_id   <= '0;
        i_now_ms    <= '0;
        in_idle_max = 10;
        out_idle_max = 10;
        wall_ms = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, bad parameters and unknown ids
        send(ptt_pkg::REQ_TICK, '1, '1, '0);
        send(ptt_pkg::REQ_START, '0, '1, '1);
        send(ptt_pkg::REQ_STOP, '0, '0, '0);
        send(ptt_pkg::REQ_REARM, 32'd7, '1, '0);
        send(ptt_pkg::REQ_STOP, '1, '1, '1);
        // arm, rearm and fire
        send(ptt_pkg::REQ_START, 32'd1, '0, '0);
        send(ptt_pkg::REQ_START, '1, '0, '0);
        send(ptt_pkg::REQ_START, 32'd5, '0, '0);
        send(ptt_pkg::REQ_REARM, '0, 5'd2, '0);
        send(ptt_pkg::REQ_REARM, 32'd3, 5'd2, '0);
        send(ptt_pkg::REQ_TICK, '0, '0, 48'd3);
        // time going backwards, then saturating deadlines
        send(ptt_pkg::REQ_TICK, '0, '0, 48'd1);
        send(ptt_pkg::REQ_TICK, '0, '0, '1);
        send(ptt_pkg::REQ_TICK, '0, '0, '1);
        send(ptt_pkg::REQ_START, '1, '0, '0);
        send(ptt_pkg::REQ_REARM, 32'd9, 5'd0, '0);
        send(ptt_pkg::REQ_TICK, '0, '0, '0);
        send(ptt_pkg::REQ_TICK, '0, '0, 48'hAAAA_5555_AAAA);
        send(ptt_pkg::REQ_STOP, '0, 5'd0, '0);
        send(ptt_pkg::REQ_STOP, '0, 5'd1, '0);
        send(ptt_pkg::REQ_STOP, '0, 5'd2, '0);
        send(ptt_pkg::REQ_STOP, '0, 5'd3, '0);
        send(ptt_pkg::REQ_TICK, '0, '0, '0);

        for (int seg = 0; seg < 6; seg++) begin
            in_idle_max  = ($urandom_range(2, 0) == 0) ? 0 : 10;
            out_idle_max = ($urandom_range(2, 0) == 0) ? 0 : 10;
            case ($urandom_range(2, 0))
                0: start_pct = 55;
                1: start_pct = 35;
                default: start_pct = 20;
            endcase
            n = 0;
            if (seg == 0 || seg == 3) begin
                // fill the table, then overrun it
                while (table_check.count_armed() < table_check.SLOTS) begin
                    send(ptt_pkg::REQ_START, pick_period(), '0, '0);
                    n++;
                end
                repeat (2) begin
                    send(ptt_pkg::REQ_START, pick_period(), '0, '0);
                    n++;
                end
            end
            while (n < 45) begin
                random_item(start_pct);
                n++;
            end
        end

        i_in_valid <= 1'b0;
        while (table_check.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (3 * ptt_pkg::DEF_NUM_TIMERS) @(posedge i_clk);
        if (table_check.errors == 0) begin
            $display("periodic_timer_table regression: pass");
        end else begin
            $display("periodic_timer_table regression: fail");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/ptt_pkg.sv
rtl/ptt_controller.sv
rtl/ptt_datapath.sv
rtl/periodic_timer_table.sv
sim/tb.sv
